### design/tccw_pkg.sv
// ----------------------------------------------------------------------------
// Text console character writer package
// Shared types, codes and stream field layout for the console block.
// ----------------------------------------------------------------------------
`default_nettype none

package tccw_pkg;

    // stream widths (fields packed from bit 0 up, padded to whole bytes)
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;
    localparam int CELL_W    = 16;

    // item kinds carried on s_tuser
    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // character codes and the attribute used by the clearing pass
    localparam logic [7:0] BLANK_CHAR   = 8'h20;
    localparam logic [7:0] NEWLINE_CODE = 8'h0A;
    localparam logic [7:0] RETURN_CODE  = 8'h0D;
    localparam logic [7:0] RESET_COLOR  = 8'h07;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_CLEAR_END,
        ST_IDLE,
        ST_EXEC,
        ST_RD_WAIT,
        ST_SCROLL,
        ST_SCROLL_END,
        ST_DONE
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic exec_put;
        logic issue_read;
        logic sweep_step;
        logic sweep_clear;
        logic load_out;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_read;
        logic need_scroll;
        logic sweep_last;
    } dp_stat_t;

endpackage

`default_nettype wire

### design/tccw_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### design/tccw_ctrl.sv
// ----------------------------------------------------------------------------
// Text console controller
// Sequences clearing, put, read and scroll sweeps; owns the stream handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module tccw_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    input  wire tccw_pkg::dp_stat_t stat,
    output tccw_pkg::dp_cmd_t      cmd
);

    import tccw_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.sweep_step  = 1'b1;
                cmd.sweep_clear = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = ST_CLEAR_END;
                end
            end
            ST_CLEAR_END:
            begin
                state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (stat.is_read)
                begin
                    cmd.issue_read = 1'b1;
                    state_next     = ST_RD_WAIT;
                end
                else
                begin
                    cmd.exec_put = 1'b1;
                    state_next   = stat.need_scroll ? ST_SCROLL : ST_DONE;
                end
            end
            ST_RD_WAIT:
            begin
                state_next = ST_DONE;
            end
            ST_SCROLL:
            begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = ST_SCROLL_END;
                end
            end
            ST_SCROLL_END:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

### design/tccw_dp.sv
// ----------------------------------------------------------------------------
// Text console datapath
// Cursor, colour, item and result registers, screen store and sweep counter.
// ----------------------------------------------------------------------------
`default_nettype none

module tccw_dp #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic [tccw_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic [0:0]                       s_tuser,
    input  wire logic [7:0]                       cfg_data,
    input  wire logic                             cfg_write,
    input  wire tccw_pkg::dp_cmd_t                cmd,
    output tccw_pkg::dp_stat_t                    stat,
    output logic      [tccw_pkg::M_TDATA_W-1:0]   m_tdata
);

    import tccw_pkg::*;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);

    logic [7:0]           color_reg;
    logic [COL_W-1:0]     col_reg;
    logic [ROW_W-1:0]     row_reg;
    logic [7:0]           char_reg;
    logic [ADDR_W-1:0]    idx_reg;
    logic                 is_read_reg;
    logic                 in_range_reg;
    logic                 scrolled_reg;
    logic [ADDR_W-1:0]    sweep_reg;
    logic                 pend_reg;
    logic [ADDR_W-1:0]    pend_addr_reg;
    logic                 pend_copy_reg;
    logic                 pend_clear_reg;
    logic [M_TDATA_W-1:0] out_reg;

    logic [COL_W:0]       col_inc;
    logic [ROW_W:0]       row_inc;
    logic [COL_W-1:0]     col_t;
    logic [ROW_W:0]       row_t;
    logic                 printable;
    logic                 need_scroll;
    logic                 sweep_copy;
    logic [ADDR_W-1:0]    put_addr;
    logic [CELL_W-1:0]    blank_cell;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [CELL_W-1:0]    ram_wdata;
    logic                 ram_re;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [CELL_W-1:0]    ram_rdata;
    logic [15:0]          rd_cell;

    // cursor step for a put
    always_comb
    begin
        col_inc   = {1'b0, col_reg} + 1'b1;
        row_inc   = {1'b0, row_reg} + 1'b1;
        printable = 1'b0;
        col_t     = '0;
        row_t     = {1'b0, row_reg};
        priority if (char_reg == NEWLINE_CODE)
        begin
            row_t = row_inc;
        end
        else if (char_reg == RETURN_CODE)
        begin
            row_t = {1'b0, row_reg};
        end
        else
        begin
            printable = 1'b1;
            if (col_inc == (COL_W+1)'(COLUMNS))
            begin
                row_t = row_inc;
            end
            else
            begin
                col_t = col_inc[COL_W-1:0];
            end
        end
        need_scroll = (row_t == (ROW_W+1)'(ROWS));
    end

    assign put_addr   = ADDR_W'(row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(col_reg);
    assign sweep_copy = !cmd.sweep_clear && (sweep_reg < ADDR_W'(CELLS - COLUMNS));
    assign blank_cell = {pend_clear_reg ? RESET_COLOR : color_reg, BLANK_CHAR};

    // memory ports: each sweep write lands in the cycle after its read
    assign ram_we    = pend_reg || (cmd.exec_put && printable);
    assign ram_waddr = pend_reg ? pend_addr_reg : put_addr;
    assign ram_wdata = pend_reg ? (pend_copy_reg ? ram_rdata : blank_cell)
                                : {color_reg, char_reg};
    assign ram_re    = (cmd.sweep_step && sweep_copy) || (cmd.issue_read && in_range_reg);
    assign ram_raddr = cmd.sweep_step ? sweep_reg + ADDR_W'(COLUMNS) : idx_reg;

    tccw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg    <= RESET_COLOR;
            col_reg      <= '0;
            row_reg      <= '0;
            scrolled_reg <= 1'b0;
            is_read_reg  <= 1'b0;
            in_range_reg <= 1'b0;
            sweep_reg    <= '0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                color_reg <= cfg_data;
            end
            if (cmd.load_item)
            begin
                is_read_reg  <= (s_tuser[0] == CMD_READ);
                in_range_reg <= (32'(s_tdata[18:8]) < CELLS);
                scrolled_reg <= 1'b0;
            end
            if (cmd.exec_put)
            begin
                col_reg      <= col_t;
                row_reg      <= need_scroll ? ROW_W'(ROWS - 1) : row_t[ROW_W-1:0];
                scrolled_reg <= need_scroll;
            end
            pend_reg <= cmd.sweep_step;
            if (cmd.sweep_step)
            begin
                // wrap to zero after the last cell, ready for the next sweep
                sweep_reg <= stat.sweep_last ? '0 : sweep_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            char_reg <= s_tdata[7:0];
            idx_reg  <= ADDR_W'(s_tdata[18:8]);
        end
        if (cmd.sweep_step)
        begin
            pend_addr_reg  <= sweep_reg;
            pend_copy_reg  <= sweep_copy;
            pend_clear_reg <= cmd.sweep_clear;
        end
        if (cmd.load_out)
        begin
            out_reg <= {3'b000, scrolled_reg, 5'(row_reg), 7'(col_reg), rd_cell};
        end
    end

    assign rd_cell = (is_read_reg && in_range_reg) ? ram_rdata : 16'h0000;

    assign stat.is_read     = is_read_reg;
    assign stat.need_scroll = need_scroll;
    assign stat.sweep_last  = (sweep_reg == ADDR_W'(CELLS - 1));

    assign m_tdata = out_reg;

endmodule

`default_nettype wire

### design/text_console_char_writer.sv
// ----------------------------------------------------------------------------
// Text console character writer
// Character-cell console with cursor, scrolling and a cell read-back port.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid / s_tready  tuser: cmd; tdata: char_code, cell_index
//  m_*       out        m_tvalid / m_tready  tdata: cell_char, cell_color, cursor
//                                            column, cursor line, scrolled
//  cfg_*     in         cfg_valid/cfg_ready  cfg_data: text_color
//
//  After reset the store is swept to blanks with s_tready low; cfg writes are
//  taken throughout. A put that scrolls also runs the row copy through the
//  single write port of the screen RAM.
//  One word is in flight at a time; a new word is taken while the previous
//  result still waits on m_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_char_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [tccw_pkg::S_TDATA_W-1:0]   s_tdata,  // [7:0] char_code, [18:8] cell_index
    input  wire logic [0:0]                       s_tuser,  // [0] cmd
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [tccw_pkg::M_TDATA_W-1:0]   m_tdata,  // [7:0] cell_char, [15:8] cell_color,
                                                            // [22:16] cursor_column,
                                                            // [27:23] cursor_line, [28] scrolled
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [7:0]                       cfg_data  // text_color
);

    import tccw_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    tccw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tccw_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_data  (cfg_data),
        .cfg_write (cfg_valid && cfg_ready),
        .cmd       (cmd),
        .stat      (stat),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

### design/tccw_checker.sv
// ----------------------------------------------------------------------------
// Text console port checker
// Port-level properties of the console, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tccw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one word in the block at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word taken while busy");

    // a scroll only comes from a put and leaves the cursor on the bottom row
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[28] |->
            m_tdata[15:0] == 16'h0000 && m_tdata[27:23] == 5'(ROWS - 1))
        else $error("scroll result malformed");

    // cursor stays on screen
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> 32'(m_tdata[22:16]) < COLUMNS && 32'(m_tdata[27:23]) < ROWS)
        else $error("cursor off screen");

endmodule

bind text_console_char_writer tccw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tccw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
